/* hw/rtl/pstt_pkg.sv */
`timescale 1ns / 1ps

package pstt_pkg;

  localparam int unsigned MaxServicesDef = 16;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned CdW     = 33;

  // request codes carried on the input tuser
  typedef enum logic [2:0] {
    REQ_CLEAR   = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_REMOVE  = 3'd2,
    REQ_GET_EN  = 3'd3,
    REQ_SET_EN  = 3'd4,
    REQ_SET_PER = 3'd5,
    REQ_TICK    = 3'd6,
    REQ_EXEC    = 3'd7
  } req_e;

  // one table entry as held in the memory
  typedef struct packed {
    logic [CdW-1:0]     countdown;
    logic [PeriodW-1:0] period;
    logic               enable;
    logic [KeyW-1:0]    key;
  } entry_t;

  // one result item
  typedef struct packed {
    logic            last;
    logic [KeyW-1:0] fired_key;
    logic            fired;
    logic            enable_out;
    logic            ok;
  } result_t;

endpackage

/* hw/rtl/periodic_service_timer_table.sv */
`timescale 1ns / 1ps

// periodic service timer table
// requests enter on the s_axis channel: tuser carries the request code (clear, insert,
// remove, get_enable, set_enable, set_period, tick, exec), tdata the key, period and
// enable bit. results leave on the m_axis channel; tlast marks the final result of a
// request. every request gives exactly one result, except exec, which gives one per
// fired entry in table order, or a single empty result when nothing fired.
// entries live in one synchronous memory with a registered read; a sequencer walks
// the live entries, reading, updating and writing back one entry at a time: a read
// state, then an evaluate state per visited entry. clear and insert need no scan;
// remove of a middle entry then reads the tail entry and writes it into the hole.
// one request is in flight at a time; the next is accepted the cycle after the last
// result has been moved into the output register. a stalled receiver holds the
// output register, and exec then waits on the next firing entry until there is room.
// reset empties the table and leaves it not ready: insert fails until a clear.
// the memory itself is never cleared; only entries below the fill count are read.

module periodic_service_timer_table
  import pstt_pkg::*;
#(
  parameter int unsigned MAX_SERVICES = MaxServicesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // service_key[15:0], period_in[47:16], enable_in[48]
  input  logic [2:0]  s_axis_tuser_i,  // req_type[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // ok[0], enable_out[1], fired[2], fired_key[18:3]
  output logic        m_axis_tlast_o
);

  localparam int unsigned IdxW = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
  localparam int unsigned CntW = $clog2(MAX_SERVICES + 1);

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_rdata;
  result_t         res;

  pstt_ctrl #(
    .MaxServices (MAX_SERVICES),
    .IdxW        (IdxW),
    .CntW        (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .req_i       (req_e'(s_axis_tuser_i)),
    .key_i       (s_axis_tdata_i[15:0]),
    .period_i    (s_axis_tdata_i[47:16]),
    .en_i        (s_axis_tdata_i[48]),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (res)
  );

  pstt_mem #(
    .Depth (MAX_SERVICES),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // pack the result item
  assign m_axis_tdata_o = {5'b0, res.fired_key, res.fired, res.enable_out, res.ok};
  assign m_axis_tlast_o = res.last;

endmodule

/* hw/rtl/pstt_mem.sv */
`timescale 1ns / 1ps

module pstt_mem
  import pstt_pkg::*;
#(
  parameter int unsigned Depth = MaxServicesDef,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/pstt_ctrl.sv */
`timescale 1ns / 1ps

module pstt_ctrl
  import pstt_pkg::*;
#(
  parameter int unsigned MaxServices = MaxServicesDef,
  parameter int unsigned IdxW        = (MaxServices > 1) ? $clog2(MaxServices) : 1,
  parameter int unsigned CntW        = $clog2(MaxServices + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  req_e               req_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [PeriodW-1:0] period_i,
  input  logic               en_i,
  // memory port
  output logic               mem_we_o,
  output logic [IdxW-1:0]    mem_waddr_o,
  output entry_t             mem_wdata_o,
  output logic [IdxW-1:0]    mem_raddr_o,
  input  entry_t             mem_rdata_i,
  // result side
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output result_t            m_res_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EV   = 3'd2;
  localparam logic [2:0] ST_RDL  = 3'd3;
  localparam logic [2:0] ST_EVL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic [CntW-1:0] CntFull = CntW'(MaxServices);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic [2:0]         state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    match_q, match_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               ready_q, ready_d;
  logic               ok_q, ok_d;
  logic               en_out_q, en_out_d;
  logic               hold_v_q, hold_v_d;
  logic [KeyW-1:0]    hold_key_q, hold_key_d;
  req_e               req_q;
  logic [KeyW-1:0]    key_q;
  logic [PeriodW-1:0] per_q;
  logic               en_q;
  logic               m_valid_q, m_valid_d;
  result_t            m_res_q, m_res_d;

  logic               out_free;
  logic               push;
  result_t            push_res;
  logic               accept;
  logic               hit;
  logic               at_end;
  logic               fire;
  logic [PeriodW-1:0] new_period;

  assign out_free   = !m_valid_q || m_ready_i;
  assign s_ready_o  = (state_q == ST_IDLE);
  assign accept     = s_valid_i && s_ready_o;
  assign hit        = (mem_rdata_i.key == key_q);
  assign at_end     = (CntW'(idx_q) == (count_q - CntOne));
  assign fire       = mem_rdata_i.enable && (mem_rdata_i.countdown == '0);
  assign new_period = (req_q == REQ_SET_PER) ? per_q : mem_rdata_i.period;
  assign mem_raddr_o = idx_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    match_d     = match_q;
    count_d     = count_q;
    ready_d     = ready_q;
    ok_d        = ok_q;
    en_out_d    = en_out_q;
    hold_v_d    = hold_v_q;
    hold_key_d  = hold_key_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    push        = 1'b0;
    push_res    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_d     = 1'b0;
          en_out_d = 1'b0;
          hold_v_d = 1'b0;
          idx_d    = '0;
          unique case (req_i)
            REQ_CLEAR: begin
              count_d = '0;
              ready_d = 1'b1;
              ok_d    = 1'b1;
              state_d = ST_FIN;
            end
            REQ_INSERT: begin
              if ((count_q != CntFull) && ready_q) begin
                mem_we_o              = 1'b1;
                mem_waddr_o           = count_q[IdxW-1:0];
                mem_wdata_o.key       = key_i;
                mem_wdata_o.enable    = en_i;
                mem_wdata_o.period    = period_i;
                mem_wdata_o.countdown = {1'b0, period_i} + CdW'(1);
                count_d               = count_q + CntOne;
                ok_d                  = 1'b1;
              end
              state_d = ST_FIN;
            end
            default: begin
              ok_d    = (req_i == REQ_TICK) || (req_i == REQ_EXEC);
              state_d = (count_q == '0) ? ST_FIN : ST_RD;
            end
          endcase
        end
      end

      ST_RD: begin
        state_d = ST_EV;
      end

      ST_EV: begin
        unique case (req_q)
          REQ_REMOVE: begin
            if (hit) begin
              if (at_end) begin
                count_d = count_q - CntOne;
                ok_d    = 1'b1;
                state_d = ST_FIN;
              end else begin
                // fetch the tail entry to move into the hole
                match_d = idx_q;
                idx_d   = IdxW'(count_q - CntOne);
                state_d = ST_RDL;
              end
            end else if (at_end) begin
              state_d = ST_FIN;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_RD;
            end
          end
          REQ_GET_EN: begin
            if (hit) begin
              ok_d     = 1'b1;
              en_out_d = mem_rdata_i.enable;
              state_d  = ST_FIN;
            end else if (at_end) begin
              state_d = ST_FIN;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_RD;
            end
          end
          REQ_SET_EN, REQ_SET_PER: begin
            if (hit) begin
              mem_we_o              = 1'b1;
              mem_wdata_o.enable    = en_q;
              mem_wdata_o.period    = new_period;
              mem_wdata_o.countdown = {1'b0, new_period} + CdW'(1);
              ok_d                  = 1'b1;
              state_d               = ST_FIN;
            end else if (at_end) begin
              state_d = ST_FIN;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_RD;
            end
          end
          REQ_TICK: begin
            if (mem_rdata_i.enable && (mem_rdata_i.countdown != '0)) begin
              mem_we_o              = 1'b1;
              mem_wdata_o.countdown = mem_rdata_i.countdown - CdW'(1);
            end
            if (at_end) begin
              state_d = ST_FIN;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_RD;
            end
          end
          REQ_EXEC: begin
            // a new firing pushes out the held one, so wait for room
            if (!(fire && hold_v_q && !out_free)) begin
              if (fire) begin
                mem_we_o              = 1'b1;
                mem_wdata_o.countdown = {1'b0, mem_rdata_i.period};
                if (hold_v_q) begin
                  push               = 1'b1;
                  push_res.ok        = 1'b1;
                  push_res.fired     = 1'b1;
                  push_res.fired_key = hold_key_q;
                end
                hold_v_d   = 1'b1;
                hold_key_d = mem_rdata_i.key;
              end
              if (at_end) begin
                state_d = ST_FIN;
              end else begin
                idx_d   = idx_q + 1'b1;
                state_d = ST_RD;
              end
            end
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end

      ST_RDL: begin
        state_d = ST_EVL;
      end

      ST_EVL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = match_q;
        count_d     = count_q - CntOne;
        ok_d        = 1'b1;
        state_d     = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          push                = 1'b1;
          push_res.ok         = ok_q;
          push_res.enable_out = en_out_q;
          push_res.fired      = hold_v_q;
          push_res.fired_key  = hold_v_q ? hold_key_q : '0;
          push_res.last       = 1'b1;
          hold_v_d            = 1'b0;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (push) begin
      m_valid_d = 1'b1;
      m_res_d   = push_res;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ready_q   <= 1'b0;
      hold_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ready_q   <= ready_d;
      hold_v_q  <= hold_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    match_q    <= match_d;
    ok_q       <= ok_d;
    en_out_q   <= en_out_d;
    hold_key_q <= hold_key_d;
    m_res_q    <= m_res_d;
    if (accept) begin
      req_q <= req_i;
      key_q <= key_i;
      per_q <= period_i;
      en_q  <= en_i;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_res_o   = m_res_q;

endmodule

/* hw/rtl/pstt_checker.sv */
`timescale 1ns / 1ps

module pstt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after an accepted item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // a fired report always succeeds
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2] |-> m_axis_tdata_o[0])
    else $error("fired result without ok");

  // anything but a fired report is the only result of its request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[2] |-> m_axis_tlast_o)
    else $error("non-fired result without last");

  // enable bit only on a successful lookup, never on a fired report
  a_enable_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |->
      m_axis_tdata_o[0] && !m_axis_tdata_o[2] && (m_axis_tdata_o[18:3] == 16'd0))
    else $error("enable reported outside a lookup");

endmodule

bind periodic_service_timer_table pstt_checker u_pstt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

/* sim/periodic_service_timer_table_tb.sv */
`timescale 1ns / 1ps

// checks the service timer table request by request against a behavioral copy of the table:
// a directed run over the empty, not-ready and duplicate-key cases, then random scenarios
// (fill to capacity and fire the enabled entries, or a random mix of requests on a
// small key pool) with random gaps on the request side and random stalls on the result side

module periodic_service_timer_table_tb;
  import pstt_pkg::*;

  localparam int unsigned Slots       = MaxServicesDef;
  localparam int unsigned RandomItems = 140;
  // longest quiet stretch in a correct run: the longest stall or gap on top of a
  // 16 entry scan; the limit leaves a wide margin
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 60;

  // behavioral copy of the table plus the queue of results it predicts
  class timer_table_scoreboard;
    logic [KeyW-1:0]    svc_key [Slots];
    logic               svc_en  [Slots];
    logic [PeriodW-1:0] svc_per [Slots];
    logic [CdW-1:0]     svc_cd  [Slots];
    int unsigned        fill;
    bit                 ready;
    result_t            pending_q[$];
    int unsigned        errors;
    int unsigned        requests;
    int unsigned        results;
    int unsigned        fires;
    int unsigned        peak_fill;
    int unsigned        peak_fires;

    function new();
      wipe();
      ready = 1'b0;
    endfunction

    function void wipe();
      for (int i = 0; i < Slots; i++) begin
        svc_key[i] = '0;
        svc_en[i]  = 1'b0;
        svc_per[i] = '0;
        svc_cd[i]  = '0;
      end
      fill = 0;
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // first live entry holding the key, -1 if none
    function int lookup(logic [KeyW-1:0] k);
      for (int i = 0; i < fill; i++) begin
        if (svc_key[i] == k) return i;
      end
      return -1;
    endfunction

    function void add_result(bit ok, bit en, bit fired, logic [KeyW-1:0] k, bit last);
      result_t r;
      r.ok         = ok;
      r.enable_out = en;
      r.fired      = fired;
      r.fired_key  = k;
      r.last       = last;
      pending_q.push_back(r);
    endfunction

    // update the table for one accepted request and queue its results
    function void note_request(req_e req, logic [KeyW-1:0] k, logic [PeriodW-1:0] p,
                               logic e);
      int      idx;
      int      tail;
      int      nfire;
      result_t r;
      requests++;
      idx = lookup(k);
      case (req)
        REQ_CLEAR: begin
          wipe();
          ready = 1'b1;
          add_result(1'b1, 1'b0, 1'b0, '0, 1'b1);
        end
        REQ_INSERT: begin
          if (fill >= Slots || !ready) begin
            add_result(1'b0, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            svc_key[fill] = k;
            svc_en[fill]  = e;
            svc_per[fill] = p;
            svc_cd[fill]  = {1'b0, p} + CdW'(1);
            fill++;
            if (fill > peak_fill) peak_fill = fill;
            add_result(1'b1, 1'b0, 1'b0, '0, 1'b1);
          end
        end
        REQ_REMOVE: begin
          if (idx < 0) begin
            add_result(1'b0, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            // tail entry moves into the hole, tail slot is zeroed
            tail = fill - 1;
            svc_key[idx] = svc_key[tail];
            svc_en[idx]  = svc_en[tail];
            svc_per[idx] = svc_per[tail];
            svc_cd[idx]  = svc_cd[tail];
            svc_key[tail] = '0;
            svc_en[tail]  = 1'b0;
            svc_per[tail] = '0;
            svc_cd[tail]  = '0;
            fill = tail;
            add_result(1'b1, 1'b0, 1'b0, '0, 1'b1);
          end
        end
        REQ_GET_EN: begin
          if (idx < 0) add_result(1'b0, 1'b0, 1'b0, '0, 1'b1);
          else add_result(1'b1, svc_en[idx], 1'b0, '0, 1'b1);
        end
        REQ_SET_EN, REQ_SET_PER: begin
          if (idx < 0) begin
            add_result(1'b0, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            if (req == REQ_SET_PER) svc_per[idx] = p;
            svc_cd[idx] = {1'b0, svc_per[idx]} + CdW'(1);
            svc_en[idx] = e;
            add_result(1'b1, 1'b0, 1'b0, '0, 1'b1);
          end
        end
        REQ_TICK: begin
          for (int i = 0; i < fill; i++) begin
            if (svc_en[i] && svc_cd[i] != 0) svc_cd[i] = svc_cd[i] - CdW'(1);
          end
          add_result(1'b1, 1'b0, 1'b0, '0, 1'b1);
        end
        default: begin
          // exec: every enabled entry at zero fires and reloads, in table order
          nfire = 0;
          for (int i = 0; i < fill; i++) begin
            if (svc_en[i] && svc_cd[i] == 0) begin
              svc_cd[i] = {1'b0, svc_per[i]};
              add_result(1'b1, 1'b0, 1'b1, svc_key[i], 1'b0);
              nfire++;
            end
          end
          if (nfire == 0) begin
            add_result(1'b1, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            r = pending_q.pop_back();
            r.last = 1'b1;
            pending_q.push_back(r);
          end
          fires += nfire;
          if (nfire > peak_fires) peak_fires = nfire;
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      results++;
      if (pending_q.size() == 0) begin
        complain($sformatf("unexpected result ok=%0b en=%0b fired=%0b key=%h last=%0b",
                           got.ok, got.enable_out, got.fired, got.fired_key, got.last));
        return;
      end
      want = pending_q.pop_front();
      if (got.ok !== want.ok || got.enable_out !== want.enable_out ||
          got.fired !== want.fired || got.fired_key !== want.fired_key ||
          got.last !== want.last) begin
        complain($sformatf({"result %0d: expected ok=%0b en=%0b fired=%0b key=%h last=%0b,",
                            " got ok=%0b en=%0b fired=%0b key=%h last=%0b"},
                           results, want.ok, want.enable_out, want.fired, want.fired_key,
                           want.last, got.ok, got.enable_out, got.fired, got.fired_key,
                           got.last));
      end
    endfunction
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [55:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = REQ_CLEAR;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tlast;

  timer_table_scoreboard board = new();

  int unsigned     idle_pct   = 0;   // chance of a gap or stall, 0 gives a clean stretch
  int unsigned     stall_left = 0;
  int unsigned     sent_items = 0;
  int unsigned     quiet      = 0;
  bit              progress;
  result_t         got;
  logic [KeyW-1:0] key_pool [6];

  periodic_service_timer_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // service_key[15:0], period_in[47:16], enable_in[48]
    .s_axis_tuser_i  (s_tuser),   // req_type[2:0]
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // ok[0], enable_out[1], fired[2], fired_key[18:3]
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 5)];
    return KeyW'($urandom_range(0, 65535));
  endfunction

  // small periods so that entries actually fire, a few full-range ones
  function automatic logic [PeriodW-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 2);
    if (r < 85) return $urandom_range(3, 12);
    return $urandom();
  endfunction

  function automatic req_e pick_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2)  return REQ_CLEAR;
    if (r < 22) return REQ_INSERT;
    if (r < 32) return REQ_REMOVE;
    if (r < 42) return REQ_GET_EN;
    if (r < 50) return REQ_SET_EN;
    if (r < 58) return REQ_SET_PER;
    if (r < 78) return REQ_TICK;
    return REQ_EXEC;
  endfunction

  // present one request and hold it until accepted; valid stays up when no gap follows
  task automatic put_request(req_e req, logic [KeyW-1:0] k, logic [PeriodW-1:0] p,
                             logic e);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'b0, e, p, k};
    do @(posedge clk_i); while (!s_tready);
    sent_items++;
    gap = ($urandom_range(0, 99) < idle_pct) ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < idle_pct) stall_left = gap_len();
    end
  end

  // both handshakes sampled at the edge; requests are noted before results are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (s_tvalid && s_tready) begin
        board.note_request(req_e'(s_tuser), s_tdata[15:0], s_tdata[47:16], s_tdata[48]);
        progress = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got.ok         = m_tdata[0];
        got.enable_out = m_tdata[1];
        got.fired      = m_tdata[2];
        got.fired_key  = m_tdata[18:3];
        got.last       = m_tlast;
        board.check_result(got);
        progress = 1'b1;
      end
      quiet = progress ? 0 : quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                 quiet, board.pending_q.size());
        $display("periodic_service_timer_table_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned base;
    int unsigned scen;
    int unsigned n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: not-ready table, empty lookups, duplicates, period zero, tail move
    idle_pct = 30;
    put_request(REQ_INSERT,  16'hFFFF, 32'hFFFF_FFFF, 1'b1);  // rejected, not ready yet
    put_request(REQ_GET_EN,  16'h0000, 32'h0, 1'b0);
    put_request(REQ_REMOVE,  16'h0000, 32'h0, 1'b0);
    put_request(REQ_SET_EN,  16'h0000, 32'h0, 1'b1);
    put_request(REQ_SET_PER, 16'h0000, 32'h0, 1'b1);
    put_request(REQ_TICK,    16'h0000, 32'h0, 1'b0);
    put_request(REQ_EXEC,    16'h0000, 32'h0, 1'b0);          // nothing to fire
    put_request(REQ_CLEAR,   16'h0000, 32'h0, 1'b0);
    put_request(REQ_INSERT,  16'h0000, 32'hFFFF_FFFF, 1'b1);  // countdown needs bit 32
    put_request(REQ_INSERT,  16'hFFFF, 32'h0, 1'b1);
    put_request(REQ_INSERT,  16'hFFFF, 32'h5, 1'b0);          // duplicate key
    put_request(REQ_GET_EN,  16'hFFFF, 32'h0, 1'b0);
    put_request(REQ_TICK,    16'h0000, 32'h0, 1'b0);
    put_request(REQ_EXEC,    16'h0000, 32'h0, 1'b0);
    put_request(REQ_EXEC,    16'h0000, 32'h0, 1'b0);          // period zero fires again
    put_request(REQ_SET_PER, 16'hFFFF, 32'h2, 1'b0);
    put_request(REQ_GET_EN,  16'hFFFF, 32'h0, 1'b0);
    put_request(REQ_REMOVE,  16'h0000, 32'h0, 1'b0);          // tail entry moves to slot 0
    put_request(REQ_SET_EN,  16'hFFFF, 32'h0, 1'b1);
    put_request(REQ_REMOVE,  16'h1234, 32'h0, 1'b0);          // no such key
    put_request(REQ_TICK,    16'h0000, 32'h0, 1'b0);
    put_request(REQ_EXEC,    16'h0000, 32'h0, 1'b0);

    // random scenarios, every fourth one fills the table and fires its enabled entries
    base = sent_items;
    scen = 0;
    while (sent_items - base < RandomItems) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      for (int i = 0; i < 6; i++) key_pool[i] = KeyW'($urandom_range(0, 65535));
      if (scen % 4 == 0) begin
        put_request(REQ_CLEAR, KeyW'($urandom_range(0, 65535)), $urandom(),
                    1'($urandom_range(0, 1)));
        // one insert more than fits
        repeat (Slots + 1)
          put_request(REQ_INSERT, pick_key(), $urandom_range(0, 1),
                      $urandom_range(0, 9) != 0);
        repeat (3) begin
          put_request(REQ_TICK, pick_key(), $urandom(), 1'($urandom_range(0, 1)));
          put_request(REQ_EXEC, pick_key(), $urandom(), 1'($urandom_range(0, 1)));
        end
      end else begin
        n = $urandom_range(8, 16);
        repeat (n)
          put_request(pick_request(), pick_key(), pick_period(), 1'($urandom_range(0, 1)));
      end
      scen++;
    end
    s_tvalid <= 1'b0;
    // let the monitor note the last accepted request first
    @(posedge clk_i);

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests and %0d results, %0d of them fired services",
             board.requests, board.results, board.fires);
    $display("fullest table %0d entries, most services fired by one exec %0d",
             board.peak_fill, board.peak_fires);
    if (board.errors == 0) begin
      $display("periodic_service_timer_table_tb: done, clean");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("periodic_service_timer_table_tb: done, errors");
    end
    $finish;
  end

endmodule
